>>> src/lzss_xor_decompressor_assert.svh
// ----------------------------------------------------------------------------
// lzss xor decompressor assertion macros
// concurrent assertion wrappers; clk and rst_n come from the enclosing scope
// ----------------------------------------------------------------------------
`ifndef LZSS_XOR_DECOMPRESSOR_ASSERT_SVH
`define LZSS_XOR_DECOMPRESSOR_ASSERT_SVH

// same-cycle implication, off during reset
`define LZX_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LZX_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define LZX_AST_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/lzx_pkg.sv
// ----------------------------------------------------------------------------
// lzx_pkg
// shared constants and types of the lzss xor decompressor
// ----------------------------------------------------------------------------
package lzx_pkg;

  localparam int WINDOW_BITS_DEF = 12;
  localparam int WINDOW_BITS_MAX = 16;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic        DESCRAMBLE_RST = 1'b1;
  localparam logic [11:0] WIN_START_RST  = 12'hfee;
  localparam logic [4:0]  MATCH_MIN      = 5'd3;

  typedef enum logic {
    REG_DESCRAMBLE = 1'b0,
    REG_WIN_START  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_LIT  = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_COPY = 1'b1
  } seq_state_t;

endpackage

>>> src/lzss_xor_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_xor_decompressor
// LZSS decoder with optional position descrambling and a windowed history
// ----------------------------------------------------------------------------
// Input stream: one compressed byte per item on in_tdata, in_tlast marks the
// final byte of a stream. Output stream: one decompressed byte per item on
// out_tdata, out_tlast marks the last byte caused by one input item.
// The APB port holds descramble_enable (0x0) and window_start (0x4); write
// them only while the block is idle.
// Flag bytes and match offset bytes give no output. A literal is written into
// the output buffer as it is accepted. A match high byte starts a copy of 3
// to 18 bytes: the copy reads the window memory one byte per cycle while the
// output buffer has room, through its single read port, and writes each byte
// back the cycle its data returns. Overlapping copies are covered by
// forwarding the byte being written.
// The window is a 2^WINDOW_BITS byte synchronous memory; a fill count marks
// which entries the current stream has written, the rest read as zero, so a
// new stream starts without a clearing pass.
// Reset (synchronous, active low) restores the registers, empties the output
// buffer and closes the stream. A two-entry output buffer lets the receiver
// stall freely; the copy and the input pause while the buffer is full.
// ----------------------------------------------------------------------------
module lzss_xor_decompressor
  import lzx_pkg::*;
#(
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input item
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] in_byte
  input  logic                  in_tlast,
  // result item
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,   // [7:0] out_byte
  output logic                  out_tlast,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int WIN_DEPTH = 1 << WINDOW_BITS;
  localparam logic [WINDOW_BITS:0] FILL_FULL = (WINDOW_BITS + 1)'(WIN_DEPTH);

  // configuration registers
  logic        descramble_r;
  logic [11:0] win_start_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  // parser
  seq_state_t  state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  flag_bits_r, flag_bits_nxt;
  logic [2:0]  flag_idx_r, flag_idx_nxt;
  logic [7:0]  offset_low_r;
  logic [7:0]  byte_pos_r;
  logic        stream_open_r;

  // window bookkeeping
  logic [WINDOW_BITS-1:0] wr_pos_r;
  logic [WINDOW_BITS-1:0] start_pos_r;
  logic [WINDOW_BITS:0]   fill_r;
  logic [WINDOW_BITS-1:0] rd_addr_r;
  logic [WINDOW_BITS-1:0] rd_dist;
  logic [WINDOW_BITS-1:0] ws_pos;
  logic [WINDOW_BITS-1:0] match_off;
  logic [WINDOW_BITS_MAX-1:0] ws_ext;
  logic [WINDOW_BITS_MAX-1:0] off_ext;
  logic [4:0]             remain_r;

  // copy pipeline
  logic        inflight_r;
  logic        inflight_last_r;
  logic        fwd_r;
  logic [7:0]  fwd_data_r;
  logic        rd_valid_r;
  logic [7:0]  mem_q_r;
  logic [7:0]  copy_byte;
  logic [7:0]  win_mem [WIN_DEPTH];

  // output buffer
  logic [1:0]  cnt_r;
  logic [7:0]  head_data_r, tail_data_r;
  logic        head_last_r, tail_last_r;
  logic [2:0]  occ_next;

  // handshake and datapath
  logic        in_acc;
  logic        pop;
  logic        push;
  logic [7:0]  push_data;
  logic        push_last;
  logic [7:0]  byte_in;
  logic        lit_acc;
  logic        match_acc;
  logic        issue;
  logic        room;
  logic        mem_we;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_DESCRAMBLE: cfg_prdata[0]    = descramble_r;
      REG_WIN_START:  cfg_prdata[11:0] = win_start_r;
      default:        cfg_prdata       = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      descramble_r <= DESCRAMBLE_RST;
      win_start_r  <= WIN_START_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DESCRAMBLE: descramble_r <= cfg_pwdata[0];
        REG_WIN_START:  win_start_r  <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- decode
  assign in_acc  = in_tvalid && in_tready;
  assign pop     = out_tvalid && out_tready;
  assign byte_in = descramble_r ? (in_tdata ^ byte_pos_r) : in_tdata;

  assign ws_ext    = WINDOW_BITS_MAX'(win_start_r);
  assign ws_pos    = ws_ext[WINDOW_BITS-1:0];
  assign off_ext   = WINDOW_BITS_MAX'({byte_in[7:4], offset_low_r});
  assign match_off = off_ext[WINDOW_BITS-1:0];

  always_comb begin
    lit_acc       = 1'b0;
    match_acc     = 1'b0;
    phase_nxt     = phase_r;
    flag_bits_nxt = flag_bits_r;
    flag_idx_nxt  = flag_idx_r;
    if (in_acc) begin
      unique case (phase_r)
        PH_LIT: begin
          if (flag_bits_r[flag_idx_r]) begin
            lit_acc      = 1'b1;
            flag_idx_nxt = flag_idx_r + 3'd1;
            phase_nxt    = (flag_idx_r == 3'd7) ? PH_FLAG : PH_LIT;
          end else begin
            phase_nxt = PH_HIGH;
          end
        end
        PH_HIGH: begin
          match_acc    = 1'b1;
          flag_idx_nxt = flag_idx_r + 3'd1;
          phase_nxt    = (flag_idx_r == 3'd7) ? PH_FLAG : PH_LIT;
        end
        default: begin
          // flag byte, also covers the unused phase code
          flag_bits_nxt = byte_in;
          flag_idx_nxt  = 3'd0;
          phase_nxt     = PH_LIT;
        end
      endcase
      if (in_tlast) begin
        phase_nxt     = PH_FLAG;
        flag_bits_nxt = 8'h00;
        flag_idx_nxt  = 3'd0;
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  // space for the byte that returns next cycle
  assign occ_next = 3'(cnt_r) + 3'(inflight_r) - 3'(pop);
  assign room     = (occ_next <= 3'd1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (match_acc) state_nxt = ST_COPY;
      ST_COPY: if (issue && (remain_r == 5'd1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = !inflight_r && (cnt_r != 2'd2);
      ST_COPY: issue     = room;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- window
  assign copy_byte = fwd_r ? fwd_data_r : (rd_valid_r ? mem_q_r : 8'h00);
  assign mem_we    = lit_acc || inflight_r;
  assign push      = mem_we;
  assign push_data = lit_acc ? byte_in : copy_byte;
  assign push_last = lit_acc ? 1'b1 : inflight_last_r;
  assign rd_dist   = rd_addr_r - start_pos_r;

  always_ff @(posedge clk) begin
    if (mem_we) win_mem[wr_pos_r] <= push_data;
    mem_q_r <= win_mem[rd_addr_r];
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      phase_r         <= PH_FLAG;
      flag_bits_r     <= 8'h00;
      flag_idx_r      <= 3'd0;
      byte_pos_r      <= 8'h00;
      stream_open_r   <= 1'b0;
      fill_r          <= '0;
      remain_r        <= 5'd0;
      inflight_r      <= 1'b0;
      inflight_last_r <= 1'b0;
      cnt_r           <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      flag_bits_r <= flag_bits_nxt;
      flag_idx_r  <= flag_idx_nxt;
      inflight_r  <= issue;
      if (issue) inflight_last_r <= (remain_r == 5'd1);
      cnt_r <= cnt_r + 2'(push) - 2'(pop);

      if (in_acc) begin
        byte_pos_r    <= in_tlast ? 8'h00 : byte_pos_r + 8'd1;
        stream_open_r <= !in_tlast;
      end

      // first byte of a stream is always a flag byte, so no write competes
      if (in_acc && !stream_open_r) begin
        fill_r <= '0;
      end else if (mem_we && (fill_r != FILL_FULL)) begin
        fill_r <= fill_r + (WINDOW_BITS + 1)'(1);
      end

      if (match_acc) begin
        remain_r <= 5'(byte_in[3:0]) + MATCH_MIN;
      end else if (issue) begin
        remain_r <= remain_r - 5'd1;
      end
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (in_acc && !stream_open_r) begin
      start_pos_r <= ws_pos;
      wr_pos_r    <= ws_pos;
    end else if (mem_we) begin
      wr_pos_r <= wr_pos_r + WINDOW_BITS'(1);
    end

    if (in_acc && (phase_r == PH_LIT) && !flag_bits_r[flag_idx_r]) begin
      offset_low_r <= byte_in;
    end

    if (match_acc) begin
      rd_addr_r <= match_off;
    end else if (issue) begin
      rd_addr_r <= rd_addr_r + WINDOW_BITS'(1);
    end

    if (issue) begin
      // read hits the entry written this cycle
      fwd_r      <= inflight_r && (rd_addr_r == wr_pos_r);
      fwd_data_r <= copy_byte;
      rd_valid_r <= ({1'b0, rd_dist} < fill_r);
    end

    unique case (cnt_r)
      2'd0: begin
        if (push) begin
          head_data_r <= push_data;
          head_last_r <= push_last;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_data_r <= push_data;
          head_last_r <= push_last;
        end else if (push) begin
          tail_data_r <= push_data;
          tail_last_r <= push_last;
        end
      end
      default: begin
        if (pop) begin
          head_data_r <= tail_data_r;
          head_last_r <= tail_last_r;
          if (push) begin
            tail_data_r <= push_data;
            tail_last_r <= push_last;
          end
        end
      end
    endcase
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = head_data_r;
  assign out_tlast  = head_last_r;

endmodule

>>> src/lzx_checker.sv
// ----------------------------------------------------------------------------
// lzx_checker
// port-level checks of the lzss xor decompressor, bound to the top level
// ----------------------------------------------------------------------------
`include "lzss_xor_decompressor_assert.svh"

module lzx_checker
  import lzx_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [7:0]            out_tdata,
  input logic                  out_tlast,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [CFG_DATA_W-1:0] cfg_pwdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata,
  input logic                  cfg_pready
);

  logic cfg_wr;

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // a stalled result item holds still
  `LZX_AST_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output item changed")

  // the output buffer is empty after reset
  `LZX_AST_RST(a_rst_empty, !rst_n, !out_tvalid, "output item present after reset")

  // the input side is open right after reset
  `LZX_AST_RST(a_rst_ready, !rst_n, in_tready, "input not ready after reset")

  // register readback follows the last write
  `LZX_AST_NXT(a_rd_descr, cfg_wr && (cfg_paddr[2] == REG_DESCRAMBLE),
    (cfg_paddr[2] != REG_DESCRAMBLE) || (cfg_prdata[0] == $past(cfg_pwdata[0])),
    "descramble_enable readback mismatch")

  `LZX_AST_NXT(a_rd_start, cfg_wr && (cfg_paddr[2] == REG_WIN_START),
    (cfg_paddr[2] != REG_WIN_START) || (cfg_prdata[11:0] == $past(cfg_pwdata[11:0])),
    "window_start readback mismatch")

endmodule

bind lzss_xor_decompressor lzx_checker u_lzx_checker (.*);

>>> tb/lzss_xor_decompressor_checker.sv
// ----------------------------------------------------------------------------
// lzss_xor_decompressor_checker
// watches the input, result and apb channels, decodes each accepted input
// item with its own lzss window and compares every result item in order
// ----------------------------------------------------------------------------
module lzss_xor_decompressor_checker
  import lzx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] in_byte
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [7:0]            out_tdata,   // [7:0] out_byte
  input  logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    fail_cnt,
  output int                    pending,
  output int                    checked
);

  localparam int WIN_W = WINDOW_BITS_DEF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_byte_t;

  out_byte_t        byte_q[$];

  logic [7:0]       hist [1 << WIN_W];
  logic [WIN_W-1:0] hist_wr;
  logic [7:0]       flags;
  logic [3:0]       flag_cnt;
  phase_t           phase;
  logic [7:0]       off_lo;
  logic [7:0]       pos;
  logic             stream_open;

  logic             cfg_desc;
  logic [11:0]      cfg_ws;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch: %s, got 0x%0h, expected 0x%0h", what, got, want);
    fail_cnt++;
  endtask

  task automatic close_stream();
    foreach (hist[i]) hist[i] = '0;
    hist_wr     = cfg_ws[WIN_W-1:0];
    flags       = '0;
    flag_cnt    = '0;
    phase       = PH_FLAG;
    off_lo      = '0;
    pos         = '0;
    stream_open = 1'b0;
  endtask

  task automatic emit(input logic [7:0] v);
    hist[hist_wr] = v;
    hist_wr++;
    byte_q.push_back('{data: v, last: 1'b0});
  endtask

  task automatic item_done();
    flag_cnt++;
    if (flag_cnt >= 4'd8) begin
      flag_cnt = '0;
      phase    = PH_FLAG;
    end else begin
      phase = PH_LIT;
    end
  endtask

  task automatic decode(input logic [7:0] raw, input logic end_mark);
    logic [7:0]       b;
    logic [WIN_W-1:0] src;
    logic [4:0]       len;
    int               base;
    base = byte_q.size();
    if (!stream_open) begin
      hist_wr     = cfg_ws[WIN_W-1:0];
      stream_open = 1'b1;
    end
    b = cfg_desc ? (raw ^ pos) : raw;
    pos++;
    case (phase)
      PH_LIT: begin
        if (flags[flag_cnt[2:0]]) begin
          emit(b);
          item_done();
        end else begin
          off_lo = b;
          phase  = PH_HIGH;
        end
      end
      PH_HIGH: begin
        src = {b[7:4], off_lo};
        len = {1'b0, b[3:0]} + MATCH_MIN;
        // byte by byte so an overlapping copy sees its own output
        for (int j = 0; j < len; j++) begin
          emit(hist[src]);
          src++;
        end
        item_done();
      end
      default: begin
        flags    = b;
        flag_cnt = '0;
        phase    = PH_LIT;
      end
    endcase
    if (byte_q.size() > base) byte_q[byte_q.size() - 1].last = 1'b1;
    if (end_mark) close_stream();
  endtask

  always @(posedge clk) begin
    out_byte_t e;
    if (!rst_n) begin
      cfg_desc = DESCRAMBLE_RST;
      cfg_ws   = WIN_START_RST;
      byte_q.delete();
      close_stream();
      fail_cnt = 0;
      checked  = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr == {REG_DESCRAMBLE, 2'b00}) cfg_desc = cfg_pwdata[0];
          else if (cfg_paddr == {REG_WIN_START, 2'b00}) cfg_ws = cfg_pwdata[11:0];
        end else begin
          if (cfg_paddr == {REG_DESCRAMBLE, 2'b00} && cfg_prdata != {31'b0, cfg_desc})
            report("descramble_enable readback", cfg_prdata, {31'b0, cfg_desc});
          if (cfg_paddr == {REG_WIN_START, 2'b00} && cfg_prdata != {20'b0, cfg_ws})
            report("window_start readback", cfg_prdata, {20'b0, cfg_ws});
        end
      end
      if (in_tvalid && in_tready) decode(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (byte_q.size() == 0) begin
          report("result item with none expected", out_tdata, '0);
        end else begin
          e = byte_q.pop_front();
          checked++;
          if (out_tdata !== e.data) report("out_byte", out_tdata, e.data);
          if (out_tlast !== e.last) report("run_last", out_tlast, e.last);
        end
      end
    end
    pending = byte_q.size();
  end

endmodule

>>> tb/lzss_xor_decompressor_test.sv
// ----------------------------------------------------------------------------
// lzss_xor_decompressor_test
// drives compressed streams and register settings into the decompressor
// ----------------------------------------------------------------------------
// A short directed pass covers byte extremes, literals, shortest and longest
// matches, offset wrap, overlapping copies, streams that end on a flag byte or
// inside a match, and a window_start change in the middle of a stream. Random
// streams follow under several register settings: mostly well formed token
// sequences that copy recent output, some cut short and some plain noise, one
// long enough to wrap the position counter. The checker does all comparing.
// ----------------------------------------------------------------------------
module lzss_xor_decompressor_test;
  import lzx_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;
  localparam int END_SETTLE  = 40;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata    = '0;   // [7:0] in_byte
  logic                  in_tlast    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [7:0]            out_tdata;          // [7:0] out_byte
  logic                  out_tlast;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int chk_fails;
  int chk_pending;
  int chk_checked;

  // stimulus side bookkeeping
  logic        cur_desc = DESCRAMBLE_RST;
  logic [11:0] cur_ws   = WIN_START_RST;
  logic [7:0]  spos     = '0;
  logic [11:0] gpos     = '0;
  int          stream_bytes;
  int          burst_left;
  int          n_items;
  int          n_streams;
  int          n_settings;
  int          cycle_cnt;
  int          rdy_left;
  logic        rdy_mode;

  always #5 clk = ~clk;

  lzss_xor_decompressor u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  lzss_xor_decompressor_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fail_cnt    (chk_fails),
    .pending     (chk_pending),
    .checked     (chk_checked)
  );

  // receiver: long ready runs, short stalls, now and then a longer one
  always @(posedge clk) begin
    int pick;
    if (rdy_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        rdy_mode = 1'b1;
        rdy_left = $urandom_range(1, 30);
      end else if (pick < 8) begin
        rdy_mode = 1'b0;
        rdy_left = $urandom_range(1, 3);
      end else begin
        rdy_mode = 1'b0;
        rdy_left = $urandom_range(4, 10);
      end
    end
    rdy_left--;
    out_tready <= rdy_mode;
  end

  // sender leaves tvalid high after an item; callers lower it before pausing
  task automatic put_in(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_tdata  <= b;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // applies the position scramble the block will undo
  task automatic send_plain(input logic [7:0] plain, input logic last);
    put_in(cur_desc ? (plain ^ spos) : plain, last);
    spos++;
    stream_bytes++;
    n_items++;
    if (last) begin
      spos = '0;
      n_streams++;
    end
  endtask

  task automatic wait_idle(input int settle);
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t r, input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (r == REG_DESCRAMBLE) cur_desc = v[0];
    else cur_ws = v[11:0];
  endtask

  task automatic cfg_read(input reg_idx_t r);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {r, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // style 0: whole tokens, 1: may stop inside a match, 2: random bytes
  task automatic gen_stream(input int target, input int style);
    logic [7:0]  flag;
    logic [11:0] off;
    logic [3:0]  len_code;
    int          pick;
    stream_bytes = 0;
    gpos         = cur_ws;
    if (style == 2) begin
      for (int i = 0; i < target; i++) send_plain(8'($urandom_range(0, 255)), i == target - 1);
      return;
    end
    forever begin
      pick = $urandom_range(0, 5);
      flag = (pick == 0) ? 8'hff : (pick == 1) ? 8'h00 : 8'($urandom_range(0, 255));
      send_plain(flag, stream_bytes + 1 >= target);
      if (stream_bytes >= target) return;
      for (int i = 0; i < 8; i++) begin
        if (flag[i]) begin
          send_plain(8'($urandom_range(0, 255)), stream_bytes + 1 >= target);
          gpos++;
        end else begin
          // mostly copy recent output, often overlapping the copy itself
          if ($urandom_range(0, 3) != 0) off = gpos - 12'($urandom_range(1, 24));
          else off = 12'($urandom_range(0, 4095));
          len_code = 4'($urandom_range(0, 15));
          if (style == 1 && stream_bytes + 1 >= target) begin
            send_plain(off[7:0], 1'b1);
            return;
          end
          send_plain(off[7:0], 1'b0);
          send_plain({off[11:8], len_code}, stream_bytes + 1 >= target);
          gpos = gpos + {8'b0, len_code} + 12'(MATCH_MIN);
        end
        if (stream_bytes >= target) return;
      end
    end
  endtask

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("lzss_xor_decompressor_test failed");
    $finish;
  end

  initial begin
    logic [7:0]  dir_a [17];
    logic        desc_set [5];
    logic [11:0] ws_set  [5];
    int          pick;
    dir_a = '{8'hff, 8'h00, 8'hff, 8'ha5, 8'h5a, 8'h80, 8'h7f, 8'h01, 8'hfe,
              8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'h1b, 8'h02, 8'h10};
    desc_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    ws_set = '{WIN_START_RST, 12'hfff, 12'h000, 12'($urandom_range(0, 4095)),
               12'($urandom_range(0, 4095))};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_read(REG_DESCRAMBLE);
    cfg_read(REG_WIN_START);

    // directed: plain bytes, window at 0
    cfg_write(REG_DESCRAMBLE, 32'd0);
    cfg_write(REG_WIN_START, 32'd0);
    n_settings++;
    // literals at both byte extremes, then shortest match, longest match
    // wrapping past the top of the window, an overlapping copy, and an end
    // that falls on a match offset byte so the match is dropped
    for (int i = 0; i < 17; i++) send_plain(dir_a[i], i == 16);
    // stream that is only a flag byte
    send_plain(8'h5c, 1'b1);
    // window_start changed mid stream only applies to the next stream
    send_plain(8'hff, 1'b0);
    send_plain(8'h33, 1'b0);
    wait_idle(SETTLE);
    cfg_write(REG_WIN_START, 32'h123);
    cfg_read(REG_WIN_START);
    n_settings++;
    send_plain(8'h44, 1'b1);
    send_plain(8'h01, 1'b0);
    send_plain(8'h99, 1'b0);
    send_plain(8'h23, 1'b0);
    send_plain(8'h10, 1'b1);

    for (int p = 0; p < 5; p++) begin
      wait_idle(SETTLE);
      cfg_write(REG_DESCRAMBLE, {31'b0, desc_set[p]});
      cfg_write(REG_WIN_START, {20'b0, ws_set[p]});
      cfg_read(REG_DESCRAMBLE);
      cfg_read(REG_WIN_START);
      n_settings++;
      if (p == 0) begin
        // long enough for the position counter to wrap
        gen_stream(258, 0);
      end else begin
        pick = $urandom_range(0, 9);
        gen_stream($urandom_range(3, 12), (pick < 7) ? 0 : (pick < 9) ? 1 : 2);
      end
    end

    wait_idle(END_SETTLE);
    $display("run covered %0d compressed bytes in %0d streams under %0d register settings",
             n_items, n_streams, n_settings);
    $display("%0d decompressed bytes compared", chk_checked);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("lzss_xor_decompressor_test passed");
    end else begin
      $display("lzss_xor_decompressor_test failed");
    end
    $finish;
  end

endmodule
